// ===== hw/rtl/lpg_pkg.sv =====
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types and constants for the line point generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int COLOR_BITS     = 16;

  typedef logic [1:0] dir_t;

  localparam dir_t DIR_ZERO = 2'd0;
  localparam dir_t DIR_POS  = 2'd1;
  localparam dir_t DIR_NEG  = 2'd3;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_t;

endpackage

// ===== hw/rtl/lpg_stepper.sv =====
// ----------------------------------------------------------------------------
// lpg_stepper
// Line state and DDA step datapath: latches a line on load, presents the
// current point and advances the error terms on each step.
// ----------------------------------------------------------------------------
module lpg_stepper
  import lpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  req_t                  req_type,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [COLOR_BITS-1:0] pixel_color,
  output logic                  emit,
  output logic [COORD_BITS-1:0] point_x,
  output logic [COORD_BITS-1:0] point_y,
  output logic [COLOR_BITS-1:0] point_color,
  output logic                  last_point
);

  localparam int EW = COORD_BITS + 1;

  logic                  busy_r, busy_nxt;
  logic [COORD_BITS-1:0] cur_col_r, cur_col_nxt;
  logic [COORD_BITS-1:0] cur_row_r, cur_row_nxt;
  logic [EW-1:0]         err_x_r, err_x_nxt;
  logic [EW-1:0]         err_y_r, err_y_nxt;
  logic [COORD_BITS-1:0] abs_dx_r, abs_dx_nxt;
  logic [COORD_BITS-1:0] abs_dy_r, abs_dy_nxt;
  logic [COORD_BITS-1:0] major_len_r, major_len_nxt;
  dir_t                  dir_x_r, dir_x_nxt;
  dir_t                  dir_y_r, dir_y_nxt;
  logic [EW-1:0]         step_cnt_r, step_cnt_nxt;
  logic [COLOR_BITS-1:0] line_color_r, line_color_nxt;

  logic [COORD_BITS-1:0] mag_x, mag_y;
  dir_t                  sdir_x, sdir_y;
  logic [EW-1:0]         sum_x, sum_y;
  logic [EW-1:0]         major_ext;
  logic                  last;

  function automatic logic [COORD_BITS-1:0] move_coord(
    input logic [COORD_BITS-1:0] c,
    input dir_t                  d
  );
    logic [COORD_BITS-1:0] r;
    case (d)
      DIR_POS: r = c + COORD_BITS'(1);
      DIR_NEG: r = c - COORD_BITS'(1);
      default: r = c;
    endcase
    return r;
  endfunction

  // load setup: magnitude and direction per axis
  always_comb begin
    if (end_x > start_x) begin
      mag_x  = end_x - start_x;
      sdir_x = DIR_POS;
    end else if (end_x == start_x) begin
      mag_x  = '0;
      sdir_x = DIR_ZERO;
    end else begin
      mag_x  = start_x - end_x;
      sdir_x = DIR_NEG;
    end
    if (end_y > start_y) begin
      mag_y  = end_y - start_y;
      sdir_y = DIR_POS;
    end else if (end_y == start_y) begin
      mag_y  = '0;
      sdir_y = DIR_ZERO;
    end else begin
      mag_y  = start_y - end_y;
      sdir_y = DIR_NEG;
    end
  end

  assign major_ext   = {1'b0, major_len_r};
  assign sum_x       = err_x_r + {1'b0, abs_dx_r};
  assign sum_y       = err_y_r + {1'b0, abs_dy_r};
  assign last        = (step_cnt_r == major_ext + EW'(1));

  assign emit        = (req_type == REQ_STEP) && busy_r;
  assign point_x     = cur_col_r;
  assign point_y     = cur_row_r;
  assign point_color = line_color_r;
  assign last_point  = last;

  always_comb begin
    busy_nxt       = busy_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    err_x_nxt      = err_x_r;
    err_y_nxt      = err_y_r;
    abs_dx_nxt     = abs_dx_r;
    abs_dy_nxt     = abs_dy_r;
    major_len_nxt  = major_len_r;
    dir_x_nxt      = dir_x_r;
    dir_y_nxt      = dir_y_r;
    step_cnt_nxt   = step_cnt_r;
    line_color_nxt = line_color_r;
    if (go) begin
      if (req_type == REQ_LOAD) begin
        abs_dx_nxt     = mag_x;
        abs_dy_nxt     = mag_y;
        dir_x_nxt      = sdir_x;
        dir_y_nxt      = sdir_y;
        major_len_nxt  = (mag_x > mag_y) ? mag_x : mag_y;
        cur_col_nxt    = start_x;
        cur_row_nxt    = start_y;
        err_x_nxt      = '0;
        err_y_nxt      = '0;
        step_cnt_nxt   = '0;
        line_color_nxt = pixel_color;
        busy_nxt       = 1'b1;
      end else if (busy_r) begin
        err_x_nxt = sum_x;
        err_y_nxt = sum_y;
        if (sum_x > major_ext) begin
          err_x_nxt   = sum_x - major_ext;
          cur_col_nxt = move_coord(cur_col_r, dir_x_r);
        end
        if (sum_y > major_ext) begin
          err_y_nxt   = sum_y - major_ext;
          cur_row_nxt = move_coord(cur_row_r, dir_y_r);
        end
        step_cnt_nxt = step_cnt_r + EW'(1);
        if (last) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      err_x_r      <= '0;
      err_y_r      <= '0;
      abs_dx_r     <= '0;
      abs_dy_r     <= '0;
      major_len_r  <= '0;
      dir_x_r      <= DIR_ZERO;
      dir_y_r      <= DIR_ZERO;
      step_cnt_r   <= '0;
      line_color_r <= '0;
    end else begin
      busy_r       <= busy_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      err_x_r      <= err_x_nxt;
      err_y_r      <= err_y_nxt;
      abs_dx_r     <= abs_dx_nxt;
      abs_dy_r     <= abs_dy_nxt;
      major_len_r  <= major_len_nxt;
      dir_x_r      <= dir_x_nxt;
      dir_y_r      <= dir_y_nxt;
      step_cnt_r   <= step_cnt_nxt;
      line_color_r <= line_color_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) && $past(rst_n) |-> $past(go && emit && last))
    else $error("run ended without a last point");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_cnt_r <= major_ext + EW'(1))
    else $error("step count past end of run");

  a_err_x_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> err_x_r <= major_ext)
    else $error("x error term out of range");

  a_err_y_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> err_y_r <= major_ext)
    else $error("y error term out of range");
`endif

endmodule

// ===== hw/rtl/line_point_generator.sv =====
// ----------------------------------------------------------------------------
// line_point_generator
// A word sits in the input register from the edge that accepts it; its
// point is then loaded into the output register that drives out_tdata and
// out_tvalid. Throughput: one word per cycle; a step uses last cycle's line
// state and waits only while an unaccepted point holds the output register.
// Reset: synchronous active-low rst_n clears the valid flags and the stepper
// state and leaves no run active; steps are ignored until a load word arrives.
// ----------------------------------------------------------------------------
module line_point_generator
  import lpg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // start_x, start_y, end_x, end_y, pixel_color (low to high), zero padded
  input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] in_tdata,
  // req_type
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // point_x, point_y, point_color (low to high), zero padded
  output logic [((2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] out_tdata,
  output logic out_tlast
);

  localparam int CB       = COORD_BITS;
  localparam int IN_BITS  = 4*CB + COLOR_BITS;
  localparam int OUT_BITS = 2*CB + COLOR_BITS;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  logic                in_valid_r;
  logic [IN_BITS-1:0]  in_data_r;
  req_t                in_req_r;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_BITS-1:0] out_data_r;
  logic                out_last_r;

  logic                go, emit, out_free;
  logic [CB-1:0]       pt_x, pt_y;
  logic [COLOR_BITS-1:0] pt_color;
  logic                pt_last;

  assign out_free  = !out_valid_r || out_tready;
  assign go        = in_valid_r && (out_free || !emit);
  assign in_tready = !in_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata[IN_BITS-1:0];
      in_req_r  <= req_t'(in_tuser);
    end
  end

  lpg_stepper #(
    .COORD_BITS (COORD_BITS)
  ) u_stepper (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (go),
    .req_type    (in_req_r),
    .start_x     (in_data_r[CB-1:0]),
    .start_y     (in_data_r[2*CB-1:CB]),
    .end_x       (in_data_r[3*CB-1:2*CB]),
    .end_y       (in_data_r[4*CB-1:3*CB]),
    .pixel_color (in_data_r[IN_BITS-1:4*CB]),
    .emit        (emit),
    .point_x     (pt_x),
    .point_y     (pt_y),
    .point_color (pt_color),
    .last_point  (pt_last)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      out_data_r <= {pt_color, pt_y, pt_x};
      out_last_r <= pt_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);
  assign out_tlast  = out_last_r;

endmodule
